/* rtl/cwam_pkg.sv */
package cwam_pkg;

	localparam int HALF_BITS  = 12;
	localparam int FD_BITS    = 20;
	localparam int IR_BITS    = 24;
	localparam int DOR_BITS   = 17;
	localparam int CFG_BITS   = 24;
	localparam int IDX_BITS   = 3;
	localparam int TRIG_W     = 41;
	localparam int PHASE_BITS = 24;
	localparam int THETA_W    = HALF_BITS + IR_BITS;
	localparam int THETA_HALF = THETA_W / 2;
	localparam int P_W        = HALF_BITS + DOR_BITS;

	localparam logic [PHASE_BITS-1:0] TWO_OVER_PI_Q24 = 24'd10680707;
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned TRIG_CAP    = 64'd1 << 40;

	localparam logic [HALF_BITS-1:0] HALF_WIDTH_RST  = 12'd320;
	localparam logic [HALF_BITS-1:0] HALF_HEIGHT_RST = 12'd240;
	localparam logic [FD_BITS-1:0]   FOCAL_DIST_RST  = 20'd126156;
	localparam logic [IR_BITS-1:0]   INV_RADIUS_RST  = 24'd28554;
	localparam logic [DOR_BITS-1:0]  DOR_RST         = 17'd54964;

	typedef enum logic [IDX_BITS-1:0] {
		REG_HALF_WIDTH  = 3'd0,
		REG_HALF_HEIGHT = 3'd1,
		REG_FOCAL_DIST  = 3'd2,
		REG_INV_RADIUS  = 3'd3,
		REG_DOR         = 3'd4
	} cfg_reg_t;

	// Long division by shift and subtract; only used while building the tables.
	function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
		longint unsigned quo, rem;
		quo = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[b] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Table node at angle i*(pi/2)/2^tbits: tan or sec in Q16, from Q30 series.
	function automatic logic [TRIG_W-1:0] trig_node(int unsigned i, int unsigned tbits,
		bit want_sec);
		longint unsigned a, a2, st, ct, t, e, r;
		longint s, c;
		a  = (longint'(i) * HALF_PI_Q30) >> tbits;
		a2 = (a * a) >> 30;
		st = a;
		ct = 64'd1 << 30;
		s  = longint'(st);
		c  = longint'(ct);
		for (int n = 0; n < 14; n++) begin
			st = udiv64((st * a2) >> 30, longint'((2 * n + 2) * (2 * n + 3)));
			ct = udiv64((ct * a2) >> 30, longint'((2 * n + 1) * (2 * n + 2)));
			if ((n & 1) == 1) begin
				s = s + longint'(st);
				c = c + longint'(ct);
			end else begin
				s = s - longint'(st);
				c = c - longint'(ct);
			end
		end
		if (s < 0) s = 0;
		if (c <= 0) begin
			r = TRIG_CAP;
		end else begin
			t = udiv64(unsigned'(s) << 16, unsigned'(c));
			e = udiv64(64'd1 << 46, unsigned'(c));
			r = want_sec ? e : t;
			if (r > TRIG_CAP) r = TRIG_CAP;
		end
		return r[TRIG_W-1:0];
	endfunction

endpackage

/* rtl/cylindrical_warp_address_map.sv */
// Cylindrical warp address map: output pixel position in, source pixel position out.
// Ten register stages from request acceptance to result valid.
// Throughput: one request per cycle; the whole pipe advances when the result is taken
// or the last stage is empty, so a stalled result freezes every stage in place.
// Reset: arst_n clears all stage valid bits and loads the default geometry registers.
module cylindrical_warp_address_map #(
	parameter int COORD_BITS      = 12,
	parameter int TRIG_TABLE_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cwam_pkg::IDX_BITS-1:0]     cfg_index,
	input  logic [cwam_pkg::CFG_BITS-1:0]     cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             out_col,
	input  logic [COORD_BITS-1:0]             out_row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COORD_BITS-1:0]             src_col,
	output logic [COORD_BITS-1:0]             src_row,
	output logic                              remapped
);
	import cwam_pkg::*;

	// Working width for centred arithmetic: holds any coordinate and twice a half size.
	localparam int EW        = ((COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS) + 2;
	localparam int SEG_SHIFT = PHASE_BITS - TRIG_TABLE_BITS;
	localparam int NODES     = (1 << TRIG_TABLE_BITS) + 1;
	localparam int PP_W      = THETA_HALF + PHASE_BITS;
	localparam int IP_W      = TRIG_W + SEG_SHIFT + 1;
	localparam int MX_W      = FD_BITS + TRIG_W;
	localparam int MYL_W     = P_W + 32;
	localparam int MYH_W     = P_W + TRIG_W - 32;

	typedef logic [TRIG_W-1:0] trig_tab_t [NODES];

	function automatic trig_tab_t build_tab(bit want_sec);
		trig_tab_t tab;
		for (int i = 0; i < NODES; i++) begin
			tab[i] = trig_node(i, TRIG_TABLE_BITS, want_sec);
		end
		return tab;
	endfunction

	localparam trig_tab_t TAN_TAB = build_tab(1'b0);
	localparam trig_tab_t SEC_TAB = build_tab(1'b1);

	// Strict window -h+1 < v < h on v = +-m / 2^shift, with the shifted bounds given.
	function automatic logic in_win(logic neg, logic [63:0] m, logic [63:0] h_sh,
		logic [63:0] hm1_sh, logic h_gt1);
		if (neg && (m != '0)) return m < hm1_sh;
		return (m < h_sh) && ((m != '0) || h_gt1);
	endfunction

	// ---------------- configuration registers ----------------
	logic [HALF_BITS-1:0] half_width_q, half_height_q;
	logic [FD_BITS-1:0]   focal_dist_q;
	logic [IR_BITS-1:0]   inv_radius_q;
	logic [DOR_BITS-1:0]  dor_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= HALF_WIDTH_RST;
			half_height_q <= HALF_HEIGHT_RST;
			focal_dist_q  <= FOCAL_DIST_RST;
			inv_radius_q  <= INV_RADIUS_RST;
			dor_q         <= DOR_RST;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_HALF_WIDTH:  half_width_q  <= cfg_data[HALF_BITS-1:0];
				REG_HALF_HEIGHT: half_height_q <= cfg_data[HALF_BITS-1:0];
				REG_FOCAL_DIST:  focal_dist_q  <= cfg_data[FD_BITS-1:0];
				REG_INV_RADIUS:  inv_radius_q  <= cfg_data[IR_BITS-1:0];
				REG_DOR:         dor_q         <= cfg_data[DOR_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- pipeline control ----------------
	// One enable for every stage: advance unless a finished result is held.
	logic adv;
	logic [10:1] vld;
	assign adv       = !vld[10] || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld[10];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (adv) begin
			vld <= {vld[9:1], in_valid};
		end
	end

	// Payload carried alongside: coordinates, signs and processed flag.
	logic [COORD_BITS-1:0] col_s [1:9];
	logic [COORD_BITS-1:0] row_s [1:9];
	logic [9:1] xneg_s, yneg_s, proc_s;

	// ---------------- stage 1: centre coordinates ----------------
	logic [EW-1:0] col_e, row_e, hw_e, hh_e, dx, dy;
	logic          proc_c;
	assign col_e  = EW'(out_col);
	assign row_e  = EW'(out_row);
	assign hw_e   = EW'(half_width_q);
	assign hh_e   = EW'(half_height_q);
	assign proc_c = (col_e != '0) && (col_e < (hw_e << 1))
		&& (row_e != '0) && (row_e < (hh_e << 1));
	assign dx = (col_e < hw_e) ? (hw_e - col_e) : (col_e - hw_e);
	assign dy = (row_e < hh_e) ? (hh_e - row_e) : (row_e - hh_e);

	logic [HALF_BITS-1:0] ax_s1, ay_s1;

	// ---------------- stage 2..10 payload ----------------
	logic [THETA_W-1:0]    theta_s2;
	logic [P_W-1:0]        p_s [2:7];
	logic [PP_W-1:0]       pl_s3, ph_s3;
	logic                  qok_s [4:9];
	logic [PHASE_BITS-1:0] q_s4;
	logic [TRIG_W-1:0]     tan0_s5, tan1_s5, sec0_s5, sec1_s5;
	logic [SEG_SHIFT-1:0]  f_s5;
	logic [IP_W-1:0]       tan_a_s6, tan_b_s6, sec_a_s6, sec_b_s6;
	logic [TRIG_W-1:0]     tn_s7, sc_s7;
	logic [MX_W-1:0]       mx_s8, mx_s9;
	logic [MYL_W-1:0]      myl_s8;
	logic [MYH_W-1:0]      myh_s8;
	logic [63:0]           my_s9;

	// Stage 4 combinational: assemble the phase product.
	logic [PP_W+THETA_HALF:0] qsum;
	assign qsum = {ph_s3, {THETA_HALF{1'b0}}} + (PP_W+THETA_HALF+1)'(pl_s3);

	// Stage 5 combinational: table segment and fraction.
	logic [TRIG_TABLE_BITS-1:0] seg;
	logic [TRIG_TABLE_BITS:0]   seg0, seg1;
	assign seg  = q_s4[PHASE_BITS-1 -: TRIG_TABLE_BITS];
	assign seg0 = {1'b0, seg};
	assign seg1 = seg0 + 1'b1;

	// Stage 6 combinational: interpolation weights.
	logic [SEG_SHIFT:0] w1, w0;
	assign w1 = {1'b0, f_s5};
	assign w0 = {1'b1, {SEG_SHIFT{1'b0}}} - w1;

	// Stage 7 combinational: blend and drop the fraction.
	logic [IP_W:0] tan_sum, sec_sum;
	assign tan_sum = {1'b0, tan_a_s6} + {1'b0, tan_b_s6};
	assign sec_sum = {1'b0, sec_a_s6} + {1'b0, sec_b_s6};

	// Stage 9 combinational: full row product with overflow flag.
	logic [MYH_W+32:0] my_full;
	assign my_full = {1'b0, myh_s8, 32'd0} + (MYH_W+33)'(myl_s8);

	// Stage 10 combinational: window test, rounding and final address.
	logic [63:0] mx64, hw_sh24, hwm1_sh24, hh_sh32, hhm1_sh32;
	logic [63:0] rx_full, ry_full;
	logic        hit;
	logic [EW-1:0] rx, ry, scol, srow;
	assign mx64      = 64'(mx_s9);
	assign hw_sh24   = 64'(half_width_q) << 24;
	assign hwm1_sh24 = 64'(half_width_q - 1'b1) << 24;
	assign hh_sh32   = 64'(half_height_q) << 32;
	assign hhm1_sh32 = 64'(half_height_q - 1'b1) << 32;
	assign hit = proc_s[9] && qok_s[9]
		&& in_win(xneg_s[9], mx64, hw_sh24, hwm1_sh24, half_width_q > 1)
		&& in_win(yneg_s[9], my_s9, hh_sh32, hhm1_sh32, half_height_q > 1);
	assign rx_full = (mx64 + (64'd1 << 23)) >> 24;
	assign ry_full = (my_s9 + (64'd1 << 31)) >> 32;
	assign rx   = rx_full[EW-1:0];
	assign ry   = ry_full[EW-1:0];
	assign scol = xneg_s[9] ? (hw_e - rx) : (hw_e + rx);
	assign srow = yneg_s[9] ? (hh_e - ry) : (hh_e + ry);

	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: capture request, fold to magnitudes
			col_s[1]  <= out_col;
			row_s[1]  <= out_row;
			xneg_s[1] <= col_e < hw_e;
			yneg_s[1] <= row_e < hh_e;
			proc_s[1] <= proc_c;
			ax_s1     <= dx[HALF_BITS-1:0];
			ay_s1     <= dy[HALF_BITS-1:0];
			// shift the carried payload
			for (int k = 2; k <= 9; k++) begin
				col_s[k]  <= col_s[k-1];
				row_s[k]  <= row_s[k-1];
				xneg_s[k] <= xneg_s[k-1];
				yneg_s[k] <= yneg_s[k-1];
				proc_s[k] <= proc_s[k-1];
			end
			// stage 2: angle in radians and row scale
			theta_s2 <= THETA_W'(ax_s1) * THETA_W'(inv_radius_q);
			p_s[2]   <= P_W'(ay_s1) * P_W'(dor_q);
			// stage 3: angle times 2/pi, split in two halves
			pl_s3  <= PP_W'(theta_s2[THETA_HALF-1:0]) * PP_W'(TWO_OVER_PI_Q24);
			ph_s3  <= PP_W'(theta_s2[THETA_W-1:THETA_HALF]) * PP_W'(TWO_OVER_PI_Q24);
			for (int k = 3; k <= 7; k++) p_s[k] <= p_s[k-1];
			// stage 4: phase as a fraction of a quarter turn
			qok_s[4] <= qsum[PP_W+THETA_HALF:PHASE_BITS+PHASE_BITS] == '0;
			q_s4     <= qsum[PHASE_BITS+PHASE_BITS-1:PHASE_BITS];
			for (int k = 5; k <= 8; k++) qok_s[k] <= qok_s[k-1];
			// stage 5: table nodes
			tan0_s5 <= TAN_TAB[seg0];
			tan1_s5 <= TAN_TAB[seg1];
			sec0_s5 <= SEC_TAB[seg0];
			sec1_s5 <= SEC_TAB[seg1];
			f_s5    <= q_s4[SEG_SHIFT-1:0];
			// stage 6: weighted nodes
			tan_a_s6 <= IP_W'(tan0_s5) * IP_W'(w0);
			tan_b_s6 <= IP_W'(tan1_s5) * IP_W'(w1);
			sec_a_s6 <= IP_W'(sec0_s5) * IP_W'(w0);
			sec_b_s6 <= IP_W'(sec1_s5) * IP_W'(w1);
			// stage 7: interpolated tan and sec
			tn_s7 <= tan_sum[SEG_SHIFT+TRIG_W-1:SEG_SHIFT];
			sc_s7 <= sec_sum[SEG_SHIFT+TRIG_W-1:SEG_SHIFT];
			// stage 8: source magnitudes, row split at bit 32
			mx_s8  <= MX_W'(focal_dist_q) * MX_W'(tn_s7);
			myl_s8 <= MYL_W'(p_s[7]) * MYL_W'(sc_s7[31:0]);
			myh_s8 <= MYH_W'(p_s[7]) * MYH_W'(sc_s7[TRIG_W-1:32]);
			// stage 9: merge row product, drop on 64-bit overflow
			mx_s9    <= mx_s8;
			my_s9    <= my_full[63:0];
			qok_s[9] <= qok_s[8] && (my_full[MYH_W+32:64] == '0);
			// stage 10: result register
			src_col  <= hit ? scol[COORD_BITS-1:0] : col_s[9];
			src_row  <= hit ? srow[COORD_BITS-1:0] : row_s[9];
			remapped <= hit;
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import cwam_pkg::*;

	localparam int COORD_BITS = 12;
	localparam int TBL_BITS   = 8;
	localparam int TBL_NODES  = (1 << TBL_BITS) + 1;
	localparam int SEG_SHIFT  = PHASE_BITS - TBL_BITS;
	// Pipeline depth given at the head of the block, plus margin.
	localparam int PIPE_DEPTH = 10;
	localparam int SETTLE     = PIPE_DEPTH + 4;

	typedef struct packed {
		logic [COORD_BITS-1:0] col;
		logic [COORD_BITS-1:0] row;
		logic                  hit;
	} src_addr_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [IDX_BITS-1:0]   cfg_index;
	logic [CFG_BITS-1:0]   cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [COORD_BITS-1:0] out_col;
	logic [COORD_BITS-1:0] out_row;
	logic                  out_valid;
	logic                  out_ready;
	logic [COORD_BITS-1:0] src_col;
	logic [COORD_BITS-1:0] src_row;
	logic                  remapped;

	cylindrical_warp_address_map #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_TABLE_BITS(TBL_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_col  (out_col),
		.out_row  (out_row),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.src_col  (src_col),
		.src_row  (src_row),
		.remapped (remapped)
	);

	// Shadow copy of the geometry registers, tracked at each accepted write.
	longint unsigned geo_hw, geo_hh, geo_fd, geo_ir, geo_dor;

	// Tangent and secant nodes in Q16 over a quarter turn.
	longint unsigned tan_nodes[TBL_NODES];
	longint unsigned sec_nodes[TBL_NODES];

	src_addr_t pending_addrs[$];
	int        mismatches;
	int        results_seen;
	int        requests_sent;
	int        remap_hits;
	int        configs_done;
	bit        stall_enable;
	int        stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Build the trig nodes from truncated Q30 Taylor series of sin and cos.
	task automatic build_trig_nodes();
		longint unsigned ang, ang2, sterm, cterm, tq, eq;
		longint sn, cs;
		for (int i = 0; i < TBL_NODES; i++) begin
			ang   = (longint'(i) * HALF_PI_Q30) >> TBL_BITS;
			ang2  = (ang * ang) >> 30;
			sterm = ang;
			cterm = 64'd1 << 30;
			sn    = longint'(sterm);
			cs    = longint'(cterm);
			for (int n = 0; n < 14; n++) begin
				sterm = ((sterm * ang2) >> 30) / longint'((2 * n + 2) * (2 * n + 3));
				cterm = ((cterm * ang2) >> 30) / longint'((2 * n + 1) * (2 * n + 2));
				if (n % 2 == 1) begin
					sn += longint'(sterm);
					cs += longint'(cterm);
				end else begin
					sn -= longint'(sterm);
					cs -= longint'(cterm);
				end
			end
			if (sn < 0) sn = 0;
			if (cs <= 0) begin
				tan_nodes[i] = TRIG_CAP;
				sec_nodes[i] = TRIG_CAP;
			end else begin
				tq = (longint'(sn) << 16) / longint'(cs);
				eq = (64'd1 << 46) / longint'(cs);
				tan_nodes[i] = (tq > TRIG_CAP) ? TRIG_CAP : tq;
				sec_nodes[i] = (eq > TRIG_CAP) ? TRIG_CAP : eq;
			end
		end
	endtask

	function automatic longint unsigned trig_lerp(bit want_sec, longint unsigned phase);
		longint unsigned seg, frac, n0, n1;
		seg  = phase >> SEG_SHIFT;
		frac = phase & ((64'd1 << SEG_SHIFT) - 1);
		n0   = want_sec ? sec_nodes[seg] : tan_nodes[seg];
		n1   = want_sec ? sec_nodes[seg+1] : tan_nodes[seg+1];
		return (n0 * ((64'd1 << SEG_SHIFT) - frac) + n1 * frac) >> SEG_SHIFT;
	endfunction

	// Strict open window -h+1 < v < h on the unrounded magnitude.
	function automatic bit in_open_window(bit neg, longint unsigned mag, longint unsigned h,
		int shift);
		if (neg && mag != 0)
			return mag < ((h - 1) << shift);
		return (mag < (h << shift)) && (mag != 0 || h > 1);
	endfunction

	function automatic src_addr_t map_pixel(logic [COORD_BITS-1:0] col,
		logic [COORD_BITS-1:0] row);
		longint unsigned c, r, ax, ay, phase, tn, sc16, mx, p, my, rx, ry, sc, sr;
		logic [127:0] wide;
		bit xneg, yneg, y_fits;
		src_addr_t res;
		c       = col;
		r       = row;
		res.col = col;
		res.row = row;
		res.hit = 1'b0;
		if (c >= 1 && c + 1 <= 2 * geo_hw && r >= 1 && r + 1 <= 2 * geo_hh) begin
			xneg  = c < geo_hw;
			yneg  = r < geo_hh;
			ax    = xneg ? geo_hw - c : c - geo_hw;
			ay    = yneg ? geo_hh - r : r - geo_hh;
			phase = (ax * geo_ir * longint'(TWO_OVER_PI_Q24)) >> 24;
			if (phase < (64'd1 << PHASE_BITS)) begin
				tn     = trig_lerp(1'b0, phase);
				sc16   = trig_lerp(1'b1, phase);
				mx     = geo_fd * tn;
				p      = ay * geo_dor;
				wide   = 128'(p) * 128'(sc16);
				// A row product past 64 bits counts as outside the window.
				y_fits = (wide[127:64] == 0);
				my     = wide[63:0];
				if (y_fits && in_open_window(xneg, mx, geo_hw, 24) &&
					in_open_window(yneg, my, geo_hh, 32)) begin
					rx      = (mx + (64'd1 << 23)) >> 24;
					ry      = (my + (64'd1 << 31)) >> 32;
					sc      = xneg ? geo_hw - rx : geo_hw + rx;
					sr      = yneg ? geo_hh - ry : geo_hh + ry;
					res.col = sc[COORD_BITS-1:0];
					res.row = sr[COORD_BITS-1:0];
					res.hit = 1'b1;
				end
			end
		end
		return res;
	endfunction

	// Append one prediction at the tail of the pending list.
	task automatic queue_prediction(src_addr_t addr);
		pending_addrs.insert(pending_addrs.size(), addr);
	endtask

	// Result checker: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		src_addr_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_addrs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] unexpected result col=%0d row=%0d remapped=%0b",
						$time, src_col, src_row, remapped);
			end else begin
				want = pending_addrs.pop_front();
				if (want.hit) remap_hits++;
				if (src_col !== want.col || src_row !== want.row || remapped !== want.hit) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] mismatch: exp col=%0d row=%0d remapped=%0b, got col=%0d row=%0d remapped=%0b",
							$time, want.col, want.row, want.hit, src_col, src_row, remapped);
				end
			end
		end
	end

	// Receiver side: random stalls, mostly short, occasionally long.
	always @(posedge clk) begin
		int roll;
		if (!stall_enable) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready  <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
				out_ready <= 1'b0;
			end
		end
	end

	// Hold the request line low for a random gap; mostly none, sometimes long.
	task automatic idle_gap();
		int roll, n;
		roll = $urandom_range(0, 99);
		n    = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Send one pixel request, predict its source address at acceptance.
	task automatic send_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row);
		idle_gap();
		in_valid <= 1'b1;
		out_col  <= col;
		out_row  <= row;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		queue_prediction(map_pixel(col, row));
		requests_sent++;
	endtask

	// Drop the request line once the stream of pixels is done.
	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	// Wait until all predictions have been matched, then let the pipe settle.
	task automatic drain_pipe();
		end_stream();
		while (pending_addrs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write one register; the caller drops the write line after its last write.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_HALF_WIDTH:  geo_hw  = value & 24'hFFF;
			REG_HALF_HEIGHT: geo_hh  = value & 24'hFFF;
			REG_FOCAL_DIST:  geo_fd  = value & 24'hFFFFF;
			REG_INV_RADIUS:  geo_ir  = value;
			REG_DOR:         geo_dor = value & 24'h1FFFF;
			default: ;
		endcase
		configs_done++;
	endtask

	task automatic set_geometry(int hw, int hh, int fd, int ir, int dor);
		write_reg(REG_HALF_WIDTH, hw);
		write_reg(REG_HALF_HEIGHT, hh);
		write_reg(REG_FOCAL_DIST, fd);
		write_reg(REG_INV_RADIUS, ir);
		write_reg(REG_DOR, dor);
		cfg_valid <= 1'b0;
	endtask

	// Pick a geometry: small or large images, angles mostly inside a quarter turn.
	task automatic random_geometry();
		int hw, hh, fd, ir, dor;
		hw  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 400);
		hh  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2048) : $urandom_range(1, 400);
		// Keep d near the radius so most sources land in the window.
		ir  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 24'hFFFFFF)
			: (longint'(1 << 24) * $urandom_range(100, 1600)) / (1000 * hw);
		fd  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 20'hFFFFF)
			: (ir == 0) ? $urandom_range(0, 20'hFFFFF)
			: ((longint'(1) << 32) / ir) * $urandom_range(80, 120) / 100;
		if (fd > 20'hFFFFF) fd = 20'hFFFFF;
		dor = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65536)
			: (longint'(fd) * ir) >> 16;
		if (dor > 65536) dor = 65536;
		set_geometry(hw, hh, fd, ir, dor);
	endtask

	task automatic random_pixel();
		logic [COORD_BITS-1:0] col, row;
		if ($urandom_range(0, 99) < 85 && geo_hw > 0 && geo_hh > 0) begin
			col = $urandom_range(1, 2 * geo_hw - 1);
			row = $urandom_range(1, 2 * geo_hh - 1);
		end else begin
			col = $urandom_range(0, 4095);
			row = $urandom_range(0, 4095);
		end
		send_pixel(col, row);
	endtask

	// Reset geometry: corners, centre, borders and the unprocessed frame.
	task automatic test_reset_geometry();
		send_pixel(0, 0);
		send_pixel(4095, 4095);
		send_pixel(1, 1);
		send_pixel(639, 479);
		send_pixel(640, 240);
		send_pixel(320, 240);
		send_pixel(320, 1);
		send_pixel(1, 240);
		send_pixel(639, 240);
		send_pixel(320, 479);
		send_pixel(320, 480);
		drain_pipe();
	endtask

	// Register extremes: zero and unit half sizes, full-size image, huge angles.
	task automatic test_register_extremes();
		set_geometry(0, 240, 126156, 28554, 54964);
		send_pixel(0, 0);
		send_pixel(1, 1);
		drain_pipe();
		set_geometry(1, 1, 126156, 28554, 54964);
		send_pixel(1, 1);
		send_pixel(2, 1);
		drain_pipe();
		// Whole angle range past a quarter turn: identity except the centre column.
		set_geometry(2048, 2048, 20'hFFFFF, 24'hFFFFFF, 65536);
		send_pixel(4095, 4095);
		send_pixel(2048, 2048);
		send_pixel(2049, 1);
		drain_pipe();
		// Edge columns just short of a quarter turn: saturated secant, row overflow.
		set_geometry(2048, 2048, 256, 12873, 65536);
		send_pixel(4095, 4095);
		send_pixel(1, 1);
		send_pixel(4095, 2048);
		send_pixel(2048, 4095);
		drain_pipe();
		set_geometry(2048, 2048, 0, 0, 0);
		send_pixel(3000, 100);
		send_pixel(100, 3000);
		drain_pipe();
	endtask

	// Random sweep across several geometries with both sides idling.
	task automatic test_random_sweep(int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				drain_pipe();
				random_geometry();
			end
			random_pixel();
		end
		drain_pipe();
	endtask

	// Back-to-back burst, pausing midway until the pipe empties.
	task automatic test_burst_with_pause();
		set_geometry(320, 240, 126156, 28554, 54964);
		for (int i = 0; i < 40; i++) begin
			if (i == 20) begin
				end_stream();
				while (pending_addrs.size() != 0) @(posedge clk);
			end
			in_valid <= 1'b1;
			out_col  <= $urandom_range(0, 700);
			out_row  <= $urandom_range(0, 500);
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			queue_prediction(map_pixel(out_col, out_row));
			requests_sent++;
		end
		drain_pipe();
	endtask

	initial begin
		int waited;
		arst_n       = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		in_valid     = 1'b0;
		out_col      = '0;
		out_row      = '0;
		out_ready    = 1'b1;
		stall_enable = 1'b0;
		stall_left   = 0;
		mismatches   = 0;
		results_seen = 0;
		requests_sent = 0;
		remap_hits   = 0;
		configs_done = 0;
		geo_hw  = HALF_WIDTH_RST;
		geo_hh  = HALF_HEIGHT_RST;
		geo_fd  = FOCAL_DIST_RST;
		geo_ir  = INV_RADIUS_RST;
		geo_dor = DOR_RST;
		build_trig_nodes();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		stall_enable = 1'b1;

		test_reset_geometry();
		test_register_extremes();
		test_burst_with_pause();
		test_random_sweep(480);

		waited = 0;
		while (pending_addrs.size() != 0 && waited < 100000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d pixel requests, checked %0d results (%0d remapped).",
			requests_sent, results_seen, remap_hits);
		$display("Applied %0d register writes; %0d mismatches.", configs_done, mismatches);
		if (mismatches == 0 && pending_addrs.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Safety net against a hung handshake.
	initial begin
		#20ms;
		$display("Timeout: %0d predictions still outstanding", pending_addrs.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
